>>> rtl/core/relay_matrix_command_framer_unit_assert.svh
// Assertion macros shared by the framer RTL.
`ifndef RELAY_MATRIX_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define RELAY_MATRIX_COMMAND_FRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define RMCF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmcf assertion failed");
// cond must never be true outside reset
`define RMCF_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rmcf forbidden condition");
`else
`define RMCF_ASSERT(label, clk, rst_n, prop)
`define RMCF_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/rmcf_pkg.sv
package rmcf_pkg;

  localparam int SHIFT_REGISTERS = 12;
  localparam int LINE_CAPACITY   = 15;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] IDLE_BYTE = 8'hC9;
  localparam logic [7:0] NO_DATA   = 8'hFF;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;

  localparam logic [3:0] PLUS_REG  [4] = '{4'd10, 4'd11, 4'd10, 4'd11};
  localparam logic [1:0] PLUS_DRV  [4] = '{2'd0, 2'd1, 2'd3, 2'd3};
  localparam logic [3:0] MINUS_REG [4] = '{4'd11, 4'd10, 4'd11, 4'd10};
  localparam logic [1:0] MINUS_DRV [4] = '{2'd2, 2'd2, 2'd0, 2'd1};
  localparam logic [2:0] SLEEP_POS [4] = '{3'd6, 3'd7, 3'd3, 3'd0};
  localparam logic [2:0] CTRL_POS  [4] = '{3'd1, 3'd5, 3'd4, 3'd2};

  typedef enum logic [2:0] {
    ST_OK  = 3'd0,
    ST_LEN = 3'd1,
    ST_ROW = 3'd2,
    ST_COL = 3'd3,
    ST_ACT = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] row_reg;
    logic [1:0] row_drv;
    logic [1:0] col;
    logic       flip;
  } cmd_t;

endpackage

>>> rtl/core/rmcf_front.sv
`include "relay_matrix_command_framer_unit_assert.svh"

module rmcf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_rx_byte,
  output logic           push,
  output rmcf_pkg::cmd_t push_cmd,
  input  logic           q_full
);

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_1  = 8'h31;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_D  = 8'h44;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  logic [7:0] chars_r [4];
  logic [3:0] count_r, count_nxt;
  logic [3:0] tlen_r, tlen_nxt;

  logic        acc, is_eol, store;
  logic [7:0]  upc;
  logic signed [12:0] d0, d1, row_s;
  logic [5:0]  ri;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_eol   = (in_rx_byte == rmcf_pkg::CHAR_CR) || (in_rx_byte == rmcf_pkg::CHAR_LF);
  assign upc      = (in_rx_byte >= CHAR_LA && in_rx_byte <= CHAR_LZ) ?
                    in_rx_byte - CASE_OFS : in_rx_byte;
  assign store    = acc && !is_eol && (in_rx_byte != rmcf_pkg::NO_DATA) &&
                    (count_r < 4'(rmcf_pkg::LINE_CAPACITY));
  assign push     = acc && is_eol && (count_r != 4'd0);

  // row = (c0-48)*10 + (c1-48)
  assign d0    = $signed({5'b0, chars_r[0]}) - 13'sd48;
  assign d1    = $signed({5'b0, chars_r[1]}) - 13'sd48;
  assign row_s = (d0 <<< 3) + (d0 <<< 1) + d1;
  assign ri    = 6'(row_s - 13'sd1);

  always_comb begin
    push_cmd         = '0;
    push_cmd.row_reg = ri[5:2];
    push_cmd.row_drv = ri[1:0];
    push_cmd.col     = 2'(chars_r[2] - CHAR_A);
    push_cmd.flip    = (chars_r[3] == CHAR_1);
    if (tlen_r != 4'd4) begin
      push_cmd.status = rmcf_pkg::ST_LEN;
    end else if (row_s < 13'sd1 || row_s > 13'sd40) begin
      push_cmd.status = rmcf_pkg::ST_ROW;
    end else if (chars_r[2] < CHAR_A || chars_r[2] > CHAR_D) begin
      push_cmd.status = rmcf_pkg::ST_COL;
    end else if (chars_r[3] != CHAR_1 && chars_r[3] != CHAR_0) begin
      push_cmd.status = rmcf_pkg::ST_ACT;
    end else begin
      push_cmd.status = rmcf_pkg::ST_OK;
    end
  end

  always_comb begin
    count_nxt = count_r;
    tlen_nxt  = tlen_r;
    if (push) begin
      count_nxt = 4'd0;
      tlen_nxt  = 4'd0;
    end else if (store) begin
      count_nxt = count_r + 4'd1;
      if (tlen_r == count_r && upc != 8'd0) begin
        tlen_nxt = tlen_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tlen_r  <= '0;
    end else begin
      count_r <= count_nxt;
      tlen_r  <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store && count_r < 4'd4) begin
      chars_r[count_r[1:0]] <= upc;
    end
  end

  `RMCF_ASSERT(a_tlen_le_count, clk, rst_n, tlen_r <= count_r)
  `RMCF_ASSERT(a_count_cap, clk, rst_n, count_r <= 4'(rmcf_pkg::LINE_CAPACITY))
  `RMCF_ASSERT(a_push_clears, clk, rst_n, push |=> (count_r == 4'd0 && tlen_r == 4'd0))

endmodule

>>> rtl/core/rmcf_queue.sv
`include "relay_matrix_command_framer_unit_assert.svh"

module rmcf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rmcf_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output rmcf_pkg::cmd_t head_cmd,
  input  logic           pop
);

  localparam int PTR_W = (rmcf_pkg::QUEUE_DEPTH > 1) ? $clog2(rmcf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rmcf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rmcf_pkg::QUEUE_DEPTH - 1);

  rmcf_pkg::cmd_t entry_r [rmcf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(rmcf_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `RMCF_NEVER(a_push_full, clk, rst_n, push && full)
  `RMCF_NEVER(a_pop_empty, clk, rst_n, pop && !head_valid)

endmodule

>>> rtl/core/rmcf_back.sv
`include "relay_matrix_command_framer_unit_assert.svh"

module rmcf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  rmcf_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_frame_byte,
  output logic [3:0]     out_byte_pos,
  output logic           out_phase,
  output logic           out_frame_end,
  output logic [2:0]     out_status,
  output logic           out_last
);

  localparam logic [3:0] LAST_POS = 4'(rmcf_pkg::SHIFT_REGISTERS - 1);

  function automatic logic [7:0] drive(logic [7:0] b, logic [1:0] drv, logic high);
    logic [7:0] r;
    r = b;
    r[rmcf_pkg::SLEEP_POS[drv]] = 1'b0;
    r[rmcf_pkg::CTRL_POS[drv]]  = high;
    return r;
  endfunction

  function automatic logic [7:0] image_byte(logic [3:0] reg_idx, rmcf_pkg::cmd_t c);
    logic [7:0] b;
    logic [3:0] creg;
    logic [1:0] cdrv;
    b    = rmcf_pkg::IDLE_BYTE;
    creg = c.flip ? rmcf_pkg::MINUS_REG[c.col] : rmcf_pkg::PLUS_REG[c.col];
    cdrv = c.flip ? rmcf_pkg::MINUS_DRV[c.col] : rmcf_pkg::PLUS_DRV[c.col];
    if (reg_idx == c.row_reg) begin
      b = drive(b, c.row_drv, c.flip);
    end
    if (reg_idx == creg) begin
      b = drive(b, cdrv, !c.flip);
    end
    return b;
  endfunction

  logic       pos_end, is_err, adv;
  logic [3:0] pos_r, pos_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic [3:0] bpos_r;
  logic       bphase_r, bend_r, blast_r;
  rmcf_pkg::status_t bstat_r;

  assign adv     = head_valid && (!out_valid_r || out_ready);
  assign is_err  = (head_cmd.status != rmcf_pkg::ST_OK);
  assign pos_end = (pos_r == LAST_POS);
  assign pop     = adv && (is_err || (pos_end && phase_r));

  always_comb begin
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (!is_err) begin
        pos_nxt = pos_end ? 4'd0 : pos_r + 4'd1;
        if (pos_end) begin
          phase_nxt = !phase_r;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_err) begin
        byte_r   <= 8'd0;
        bpos_r   <= 4'd0;
        bphase_r <= 1'b0;
        bend_r   <= 1'b0;
        bstat_r  <= head_cmd.status;
        blast_r  <= 1'b1;
      end else begin
        byte_r   <= phase_r ? rmcf_pkg::IDLE_BYTE : image_byte(LAST_POS - pos_r, head_cmd);
        bpos_r   <= pos_r;
        bphase_r <= phase_r;
        bend_r   <= pos_end;
        bstat_r  <= rmcf_pkg::ST_OK;
        blast_r  <= pos_end && phase_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_byte_pos   = bpos_r;
  assign out_phase      = bphase_r;
  assign out_frame_end  = bend_r;
  assign out_status     = bstat_r;
  assign out_last       = blast_r;

  `RMCF_ASSERT(a_ok_last, clk, rst_n,
    (out_valid_r && blast_r && bstat_r == rmcf_pkg::ST_OK) |-> (bphase_r && bpos_r == LAST_POS))
  `RMCF_ASSERT(a_err_frame_start, clk, rst_n,
    (head_valid && is_err) |-> (pos_r == 4'd0 && !phase_r))
  `RMCF_ASSERT(a_pos_range, clk, rst_n, pos_r <= LAST_POS)

endmodule

>>> rtl/core/relay_matrix_command_framer_unit.sv
// Relay matrix command framer.
// Input channel (in_valid/in_ready/in_rx_byte): one console byte per transfer.
// 0xFF is dropped; other bytes build a line; CR or LF closes a non-empty line.
// Each closed line yields either one status result (last=1) or 24 results:
// the 12-byte pulse image (phase 0) then the 12-byte idle image (phase 1),
// frame_end on byte_pos 11 of each image, last on the final idle byte.
// Output channel (out_valid/out_ready/out_*): one result per transfer.
// With the back end idle, a closed line is first written into the command
// queue, and its first result is then registered in the output register.
// The back end emits one result per cycle while out_ready is high and a
// command is queued. A two-entry command queue sits between line assembly
// and frame generation, so bytes are taken every cycle until two closed
// lines are pending; in_ready drops only while that queue is full.
// When out_ready is low the output register holds its result and the back end
// waits; line assembly keeps taking bytes until the queue is full. Reset clears
// the line, the queue and the output valid flag; no results are pending after reset.
`include "relay_matrix_command_framer_unit_assert.svh"

module relay_matrix_command_framer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic [3:0] out_byte_pos,
  output logic       out_phase,
  output logic       out_frame_end,
  output logic [2:0] out_status,
  output logic       out_last
);

  logic           push, q_full, head_valid, pop;
  rmcf_pkg::cmd_t push_cmd, head_cmd;

  rmcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  rmcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  rmcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_byte_pos   (out_byte_pos),
    .out_phase      (out_phase),
    .out_frame_end  (out_frame_end),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  `RMCF_ASSERT(a_stall_holds, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_frame_byte) && $stable(out_last)))
  `RMCF_ASSERT(a_end_pos, clk, rst_n, (out_valid && out_frame_end) |-> (out_byte_pos == 4'd11))

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

localparam int SHIFT_REG_COUNT = 12;
localparam int LINE_LIMIT      = 15;
localparam int ROW_COUNT       = 40;

localparam logic [7:0] ASCII_CR   = 8'd13;
localparam logic [7:0] ASCII_LF   = 8'd10;
localparam logic [7:0] RX_NONE    = 8'hFF;
localparam logic [7:0] IDLE_IMAGE = 8'hC9;

localparam int PLUS_SIDE_REG  [4] = '{10, 11, 10, 11};
localparam int PLUS_SIDE_DRV  [4] = '{0, 1, 3, 3};
localparam int MINUS_SIDE_REG [4] = '{11, 10, 11, 10};
localparam int MINUS_SIDE_DRV [4] = '{2, 2, 0, 1};
localparam int DRV_SLEEP_BIT  [4] = '{6, 7, 3, 0};
localparam int DRV_CTRL_BIT   [4] = '{1, 5, 4, 2};

typedef struct packed {
  logic [7:0]        frame_byte;
  logic [3:0]        byte_pos;
  logic              phase;
  logic              frame_end;
  rmcf_pkg::status_t status;
  logic              last;
} frame_result_t;

class frame_scoreboard;
  frame_result_t pending_frames[$];
  logic [7:0]    line_chars[4];
  logic [7:0]    pulse_image[SHIFT_REG_COUNT];
  logic [3:0]    stored_count = '0;
  logic [3:0]    text_length  = '0;
  int            received     = 0;
  int            failures     = 0;

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function void push_frame(logic [7:0] fb, int pos, bit ph, bit fe,
                           rmcf_pkg::status_t st, bit lst);
    frame_result_t r;
    r.frame_byte = fb;
    r.byte_pos   = 4'(pos);
    r.phase      = ph;
    r.frame_end  = fe;
    r.status     = st;
    r.last       = lst;
    pending_frames.push_back(r);
  endfunction

  // enabling a driver clears its sleep bit and sets its control level
  function void enable_drv(int sr, int drv, bit high);
    pulse_image[sr][DRV_SLEEP_BIT[drv]] = 1'b0;
    pulse_image[sr][DRV_CTRL_BIT[drv]]  = high;
  endfunction

  function void close_line();
    int row;
    int col;
    bit flip;
    if (text_length != 4'd4) begin
      push_frame(8'h00, 0, 1'b0, 1'b0, rmcf_pkg::ST_LEN, 1'b1);
      return;
    end
    row = (int'(line_chars[0]) - 48) * 10 + (int'(line_chars[1]) - 48);
    if (row < 1 || row > ROW_COUNT) begin
      push_frame(8'h00, 0, 1'b0, 1'b0, rmcf_pkg::ST_ROW, 1'b1);
      return;
    end
    if (line_chars[2] < "A" || line_chars[2] > "D") begin
      push_frame(8'h00, 0, 1'b0, 1'b0, rmcf_pkg::ST_COL, 1'b1);
      return;
    end
    col = int'(line_chars[2]) - int'("A");
    if (line_chars[3] == "1") begin
      flip = 1'b1;
    end else if (line_chars[3] == "0") begin
      flip = 1'b0;
    end else begin
      push_frame(8'h00, 0, 1'b0, 1'b0, rmcf_pkg::ST_ACT, 1'b1);
      return;
    end
    foreach (pulse_image[i]) pulse_image[i] = IDLE_IMAGE;
    enable_drv((row - 1) / 4, (row - 1) % 4, flip);
    if (flip) begin
      enable_drv(MINUS_SIDE_REG[col], MINUS_SIDE_DRV[col], 1'b0);
    end else begin
      enable_drv(PLUS_SIDE_REG[col], PLUS_SIDE_DRV[col], 1'b1);
    end
    for (int p = 0; p < SHIFT_REG_COUNT; p++) begin
      push_frame(pulse_image[SHIFT_REG_COUNT - 1 - p], p, 1'b0,
                 p == SHIFT_REG_COUNT - 1, rmcf_pkg::ST_OK, 1'b0);
    end
    for (int p = 0; p < SHIFT_REG_COUNT; p++) begin
      push_frame(IDLE_IMAGE, p, 1'b1, p == SHIFT_REG_COUNT - 1, rmcf_pkg::ST_OK,
                 p == SHIFT_REG_COUNT - 1);
    end
  endfunction

  function void take_console_byte(logic [7:0] rx);
    logic [7:0] c;
    c = rx;
    if (c == RX_NONE) return;
    if (c == ASCII_CR || c == ASCII_LF) begin
      if (stored_count != 4'd0) close_line();
      stored_count = '0;
      text_length  = '0;
      return;
    end
    if (stored_count < LINE_LIMIT) begin
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (stored_count < 4'd4) line_chars[stored_count[1:0]] = c;
      if (text_length == stored_count && c != 8'h00) text_length = text_length + 4'd1;
      stored_count = stored_count + 4'd1;
    end
  endfunction

  function void check_frame_result(frame_result_t got);
    frame_result_t want;
    received++;
    if (pending_frames.size() == 0) begin
      note_failure($sformatf("unexpected byte %h pos %0d phase %0d end %0d st %0d last %0d",
                             got.frame_byte, got.byte_pos, got.phase, got.frame_end,
                             got.status, got.last));
      return;
    end
    want = pending_frames.pop_front();
    if (got.frame_byte !== want.frame_byte || got.byte_pos !== want.byte_pos ||
        got.phase !== want.phase || got.frame_end !== want.frame_end ||
        got.status !== want.status || got.last !== want.last) begin
      note_failure($sformatf({"exp byte %h pos %0d phase %0d end %0d st %0d last %0d, ",
                              "got byte %h pos %0d phase %0d end %0d st %0d last %0d"},
                             want.frame_byte, want.byte_pos, want.phase, want.frame_end,
                             want.status, want.last, got.frame_byte, got.byte_pos,
                             got.phase, got.frame_end, got.status, got.last));
    end
  endfunction
endclass

module testbench;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_frame_byte;
  logic [3:0] out_byte_pos;
  logic       out_phase;
  logic       out_frame_end;
  logic [2:0] out_status;
  logic       out_last;

  frame_scoreboard sb;
  logic [7:0]      line_q[$];
  int              fed_bytes = 0;

  relay_matrix_command_framer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_byte_pos   (out_byte_pos),
    .out_phase      (out_phase),
    .out_frame_end  (out_frame_end),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // any byte that does not end the line
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ASCII_CR || b == ASCII_LF);
    return b;
  endfunction

  // sends line_q; some lines go back to back with no idle cycles
  task automatic send_line();
    bit burst;
    int gap;
    burst = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) begin
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= line_q[i];
      do @(posedge clk); while (!in_ready);
      sb.take_console_byte(line_q[i]);
      if (line_q[i] != RX_NONE) fed_bytes++;
    end
  endtask

  initial begin : stimulus
    int kind;
    int row;
    int n;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    line_q = {"0", "1", "a", "1", ASCII_LF};
    send_line();
    line_q = {"4", "0", RX_NONE, "D", "0", ASCII_CR};
    send_line();
    line_q = {ASCII_CR};
    send_line();
    line_q = {"0", 8'h00, "B", "1", ASCII_CR};
    send_line();
    line_q = {"4", "1", "c", 8'h80, ASCII_LF};
    send_line();

    while (fed_bytes < 110) begin
      line_q = {};
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        n = $urandom_range(0, 18);
        repeat (n) line_q.push_back(line_byte());
      end else begin
        row = $urandom_range(1, ROW_COUNT);
        line_q.push_back(8'(48 + row / 10));
        line_q.push_back(8'(48 + row % 10));
        line_q.push_back(8'("A" + $urandom_range(0, 3) + ($urandom_range(0, 1) ? 32 : 0)));
        line_q.push_back($urandom_range(0, 1) ? "1" : "0");
        case (kind)
          5: line_q[2] = line_byte();
          6: line_q[3] = line_byte();
          7: begin
            if ($urandom_range(0, 1)) line_q[0] = 8'(48 + $urandom_range(4, 9));
            else line_q[$urandom_range(0, 1)] = line_byte();
          end
          9: begin
            line_q.push_back(8'h00);
            n = $urandom_range(15, 20);
            while (line_q.size() < n) line_q.push_back(line_byte());
          end
          default: begin
            if ($urandom_range(0, 3) == 0) line_q.insert($urandom_range(1, 3), RX_NONE);
          end
        endcase
      end
      line_q.push_back($urandom_range(0, 1) ? ASCII_CR : ASCII_LF);
      send_line();
    end
    in_valid <= 1'b0;

    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    frame_result_t got;
    bit held;
    int calm;
    int gap;
    held = 1'b0;
    calm = 0;
    @(posedge rst_n);
    forever begin
      // one long hold-off lets the command queue fill and back up the input
      if (!held && sb.received >= 40) begin
        gap  = 400;
        held = 1'b1;
      end else if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.frame_byte = out_frame_byte;
      got.byte_pos   = out_byte_pos;
      got.phase      = out_phase;
      got.frame_end  = out_frame_end;
      got.status     = rmcf_pkg::status_t'(out_status);
      got.last       = out_last;
      sb.check_frame_result(got);
    end
  end

  initial begin : watchdog
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
